// ===== rtl/rse_pkg.sv =====
// Package for the running Shannon entropy block: widths, sequencer codes and types.
// Used by every module in rtl/; depends on nothing.
package rse_pkg;
  localparam int unsigned SymW   = 8;
  localparam int unsigned Symbols = 256;
  localparam int unsigned CntW   = 24;
  localparam int unsigned ExtW   = 12;
  localparam int unsigned FracW  = 16;
  localparam int unsigned EntW   = 20;
  localparam int unsigned SumW   = 48;
  localparam int unsigned LogW   = 5 + FracW;
  localparam int unsigned MantW  = 64;
  localparam int unsigned SqW    = 2 * (MantW - 1);
  localparam int unsigned QuoW   = SumW;

  localparam logic [EntW-1:0] EntMax = '1;
  localparam logic [CntW-1:0] CntMax = '1;

  localparam int unsigned StW = 4;
  localparam logic [StW-1:0] StIdle  = 4'd0;
  localparam logic [StW-1:0] StClear = 4'd1;
  localparam logic [StW-1:0] StRead  = 4'd2;
  localparam logic [StW-1:0] StCheck = 4'd3;
  localparam logic [StW-1:0] StLogF  = 4'd4;
  localparam logic [StW-1:0] StLogNf = 4'd5;
  localparam logic [StW-1:0] StMulF  = 4'd6;
  localparam logic [StW-1:0] StMulNf = 4'd7;
  localparam logic [StW-1:0] StLogN  = 4'd8;
  localparam logic [StW-1:0] StDiv   = 4'd9;
  localparam logic [StW-1:0] StOut   = 4'd10;
  localparam logic [StW-1:0] StWait  = 4'd11;

  localparam logic [1:0] PhLo  = 2'd0;
  localparam logic [1:0] PhMid = 2'd1;
  localparam logic [1:0] PhHi  = 2'd2;

  typedef struct packed {
    logic start;
    logic [CntW-1:0] arg;
  } log_req_t;

  typedef struct packed {
    logic done;
    logic [LogW-1:0] res;
  } log_rsp_t;
endpackage

// ===== rtl/rse_log2.sv =====
// Iterative fixed-point log2: each squaring of the mantissa is built from three
// products of a 32-by-32 multiplier. Depends on rse_pkg.
// The argument must be at least one.
module rse_log2 (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rse_pkg::log_req_t req_i,
  output rse_pkg::log_rsp_t rsp_o
);
  import rse_pkg::*;

  localparam int unsigned CntIdxW = $clog2(FracW + 2);

  logic [MantW-2:0] m_q, m_d;
  logic [FracW:0] r_q, r_d;
  logic [4:0] k_q, k_d;
  logic [CntIdxW-1:0] n_q, n_d;
  logic [1:0] ph_q, ph_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [4:0] k_c;
  logic [31:0] opa, opb;
  logic [63:0] mp;
  logic [SqW-1:0] acc_q, acc_d, sq;
  logic [MantW-1:0] sq_s;

  always_comb begin
    k_c = '0;
    for (int i = 0; i < CntW; i++) begin
      if (req_i.arg[i]) k_c = 5'(i);
    end
  end

  always_comb begin
    case (ph_q)
      PhLo: begin
        opa = m_q[31:0]; opb = m_q[31:0];
      end
      PhMid: begin
        opa = m_q[31:0]; opb = {1'b0, m_q[MantW-2:32]};
      end
      default: begin
        opa = {1'b0, m_q[MantW-2:32]}; opb = {1'b0, m_q[MantW-2:32]};
      end
    endcase
  end

  assign mp   = opa * opb;
  assign sq   = acc_q + (SqW'(mp) << 64);
  assign sq_s = sq[SqW-1 -: MantW];

  always_comb begin
    m_d = m_q; r_d = r_q; k_d = k_q; n_d = n_q; ph_d = ph_q; acc_d = acc_q;
    busy_d = busy_q; done_d = 1'b0;
    if (req_i.start) begin
      k_d = k_c;
      m_d = (MantW-1)'((MantW-1)'(req_i.arg) << (MantW - 2 - k_c));
      r_d = '0; n_d = '0; ph_d = PhLo; busy_d = 1'b1;
    end else if (busy_q) begin
      case (ph_q)
        PhLo: begin
          acc_d = SqW'(mp); ph_d = PhMid;
        end
        PhMid: begin
          // The cross product of the two halves appears twice in the square.
          acc_d = acc_q + (SqW'(mp) << 33); ph_d = PhHi;
        end
        default: begin
          ph_d = PhLo;
          if (sq_s[MantW-1]) begin
            m_d = sq_s[MantW-1:1]; r_d = {r_q[FracW-1:0], 1'b1};
          end else begin
            m_d = sq_s[MantW-2:0]; r_d = {r_q[FracW-1:0], 1'b0};
          end
          n_d = n_q + 1'b1;
          if (n_q == CntIdxW'(FracW)) begin
            busy_d = 1'b0; done_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; n_q <= '0; ph_q <= PhLo;
    end else begin
      busy_q <= busy_d; done_q <= done_d; n_q <= n_d; ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d; r_q <= r_d; k_q <= k_d; acc_q <= acc_d;
  end

  logic [LogW:0] full;
  assign full = {k_q, r_q} + 1'b1;
  assign rsp_o.done = done_q;
  assign rsp_o.res  = full[LogW:1];
endmodule

// ===== rtl/rse_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on rse_pkg.
module rse_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rse_pkg::SumW-1:0]  num_i,
  input  logic [rse_pkg::CntW-1:0]  den_i,
  output logic                      done_o,
  output logic [rse_pkg::QuoW-1:0]  quo_o
);
  import rse_pkg::*;

  localparam int unsigned NW = $clog2(SumW + 1);

  logic [SumW-1:0] q_q, q_d;
  logic [CntW:0] rem_q, rem_d;
  logic [CntW-1:0] den_q, den_d;
  logic [NW-1:0] n_q, n_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [CntW:0] trial;

  assign trial = {rem_q[CntW-1:0], q_q[SumW-1]} - {1'b0, den_q};

  always_comb begin
    q_d = q_q; rem_d = rem_q; den_d = den_q; n_d = n_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      q_d = num_i; rem_d = '0; den_d = den_i; n_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[CntW]) begin
        rem_d = trial; q_d = {q_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[CntW-1:0], q_q[SumW-1]}; q_d = {q_q[SumW-2:0], 1'b0};
      end
      n_d = n_q + 1'b1;
      if (n_q == NW'(SumW - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; n_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; n_q <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = q_q;
endmodule

// ===== rtl/running_shannon_entropy_top.sv =====
// Top level of the running Shannon entropy block: sequencer, count memory, totals.
// Depends on rse_pkg, rse_log2 and rse_div.
//
//   channel | handshake                | beat fields
//   in      | in_valid_i / in_ready_o  | new_sequence_i, symbol_i, extra_count_i
//   out     | out_valid_o / out_ready_i| entropy_o, overflow_o
//
// An item runs three log2 passes of 17 squarings each, every squaring built from three
// multiplier products, and then a divide; the shared log2 unit and divider do this work.
// A zero count skips its log2 pass, an empty prior total skips the last log2 pass and the
// divide, and an overflow of the count or total skips all of them.
// After reset, and for each beat with new_sequence_i set, a clearing pass sweeps all 256
// entries of the count memory one entry per cycle before the item continues.
// The block takes the next beat only after the result beat has been taken.
module running_shannon_entropy_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       new_sequence_i,
  input  logic [rse_pkg::SymW-1:0]   symbol_i,
  input  logic [rse_pkg::ExtW-1:0]   extra_count_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [rse_pkg::EntW-1:0]   entropy_o,
  output logic                       overflow_o
);
  import rse_pkg::*;

  logic [CntW-1:0] mem [Symbols];
  logic [CntW-1:0] rd_q;
  logic [SymW-1:0] addr_q, addr_d;
  logic [StW-1:0] st_q, st_d;
  logic [SymW-1:0] sym_q;
  logic [ExtW-1:0] ext_q;
  logic pend_q, pend_d;
  logic [CntW-1:0] tot_q, tot_d, f_q, f_d, prev_q, prev_d;
  logic [CntW:0] nf, nt;
  logic [SumW-1:0] sum_q, sum_d;
  logic [LogW-1:0] lf_q, lf_d, lnf_q, lnf_d, ln_q, ln_d;
  logic [EntW-1:0] ent_q, ent_d;
  logic ovf_q, ovf_d;
  logic we;
  logic [CntW-1:0] wdata;
  log_req_t lreq;
  log_rsp_t lrsp;
  logic dstart, ddone;
  logic [QuoW-1:0] quo;
  logic [CntW+LogW-1:0] prod;
  logic [CntW-1:0] marg;
  logic [LogW-1:0] mlog;

  rse_log2 u_log (.clk_i, .rst_ni, .req_i(lreq), .rsp_o(lrsp));
  rse_div u_div (.clk_i, .rst_ni, .start_i(dstart), .num_i(sum_q), .den_i(tot_q),
    .done_o(ddone), .quo_o(quo));

  assign nf = {1'b0, f_q} + (CntW+1)'(ext_q);
  assign nt = {1'b0, tot_q} + (CntW+1)'(ext_q);
  assign marg = (st_q == StMulF) ? f_q : nf[CntW-1:0];
  assign mlog = (st_q == StMulF) ? lf_q : lnf_q;
  assign prod = marg * mlog;

  always_ff @(posedge clk_i) begin
    if (we) mem[addr_q] <= wdata;
    rd_q <= mem[sym_q];
    if (in_valid_i && in_ready_o) begin
      sym_q <= symbol_i; ext_q <= extra_count_i;
    end
  end

  always_comb begin
    st_d = st_q; addr_d = addr_q; pend_d = pend_q; tot_d = tot_q; f_d = f_q;
    prev_d = prev_q; sum_d = sum_q; lf_d = lf_q; lnf_d = lnf_q; ln_d = ln_q;
    ent_d = ent_q; ovf_d = ovf_q; we = 1'b0; wdata = '0;
    lreq.start = 1'b0; lreq.arg = f_q; dstart = 1'b0;
    case (st_q)
      StIdle: begin
        if (in_valid_i) begin
          if (new_sequence_i) begin
            st_d = StClear; addr_d = '0; pend_d = 1'b1;
            tot_d = '0; sum_d = '0;
          end else begin
            st_d = StRead; addr_d = symbol_i;
          end
        end
      end
      StClear: begin
        we = 1'b1; addr_d = addr_q + 1'b1;
        if (addr_q == SymW'(Symbols - 1)) begin
          st_d = pend_q ? StRead : StIdle;
          pend_d = 1'b0;
          if (pend_q) addr_d = sym_q;
        end
      end
      StRead: st_d = StCheck;
      StCheck: begin
        f_d = rd_q; st_d = StLogF;
      end
      StLogF: begin
        if (nf[CntW] || nt[CntW]) begin
          ovf_d = 1'b1; ent_d = '0; st_d = StOut;
        end else begin
          ovf_d = 1'b0; prev_d = tot_q;
          lreq.start = (f_q != '0); lreq.arg = f_q;
          lf_d = '0;
          st_d = StLogNf;
          if (f_q != '0) st_d = StWait;
        end
      end
      StWait: begin
        if (lrsp.done) begin
          lf_d = lrsp.res; st_d = StLogNf;
        end
      end
      StLogNf: begin
        if (nf[CntW-1:0] == '0) begin
          lnf_d = '0; st_d = StMulF;
        end else if (!pend_q) begin
          lreq.start = 1'b1; lreq.arg = nf[CntW-1:0]; pend_d = 1'b1;
        end else if (lrsp.done) begin
          lnf_d = lrsp.res; pend_d = 1'b0; st_d = StMulF;
        end
      end
      StMulF: begin
        sum_d = sum_q - SumW'(prod); st_d = StMulNf;
      end
      StMulNf: begin
        sum_d = sum_q + SumW'(prod);
        we = 1'b1; wdata = nf[CntW-1:0];
        tot_d = nt[CntW-1:0];
        if (prev_q == '0) begin
          ent_d = '0; st_d = StOut;
        end else begin
          st_d = StLogN;
        end
      end
      StLogN: begin
        if (!pend_q) begin
          lreq.start = 1'b1; lreq.arg = tot_q; pend_d = 1'b1;
        end else if (lrsp.done) begin
          ln_d = lrsp.res; pend_d = 1'b0; dstart = 1'b1; st_d = StDiv;
        end
      end
      StDiv: begin
        if (ddone) begin
          if (QuoW'(ln_q) <= quo) ent_d = '0;
          else if (QuoW'(ln_q) - quo > QuoW'(EntMax)) ent_d = EntMax;
          else ent_d = EntW'(QuoW'(ln_q) - quo);
          st_d = StOut;
        end
      end
      StOut: if (out_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  assign in_ready_o = (st_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear; addr_q <= '0; pend_q <= 1'b0; tot_q <= '0; sum_q <= '0;
    end else begin
      st_q <= st_d; pend_q <= pend_d; tot_q <= tot_d; sum_q <= sum_d;
      addr_q <= addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q <= f_d; prev_q <= prev_d; lf_q <= lf_d; lnf_q <= lnf_d; ln_q <= ln_d;
    ent_q <= ent_d; ovf_q <= ovf_d;
  end

  assign out_valid_o = (st_q == StOut);
  assign entropy_o   = ent_q;
  assign overflow_o  = ovf_q;
endmodule

// ===== rtl/rse_checker.sv =====
// Port-level checker for the running Shannon entropy block, bound to the top level.
// Depends on rse_pkg and running_shannon_entropy_top.
module rse_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [rse_pkg::EntW-1:0] entropy_o,
  input logic                     overflow_o
);
  import rse_pkg::*;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while a result waits");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("ready after accept");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(entropy_o)))
    else $error("result beat dropped");
  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> (entropy_o == '0)) else $error("overflow value");
endmodule

bind running_shannon_entropy_top rse_checker u_rse_checker (.*);
